/* rtl/dwd_pkg.sv */
// ----------------------------------------------------------------------------
// dwd_pkg
// shared types and constants of the derivative weighted decimator
// ----------------------------------------------------------------------------
package dwd_pkg;

  // configuration port
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_COLLECTION_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH    = 1'b1;

  localparam logic                  RESET_COLLECTION_MODE = 1'b1;
  localparam logic [CFG_DATA_W-1:0] RESET_BLOCK_LENGTH    = 6'd10;

  // block index width, wraps modulo 2048
  localparam int IDX_W = 11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FEED,
    ST_DSTART,
    ST_DIV,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic capture;
    logic feed;
    logic div_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic block_done;
    logic div_done;
    logic out_room;
  } stat_t;

endpackage

/* rtl/dwd_div.sv */
// ----------------------------------------------------------------------------
// dwd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module dwd_div #(
  parameter int DVD_W = 28,
  parameter int DIV_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsr;
  logic [DVD_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DIV_W:0]   trial;
  logic             fits;
  logic [DIV_W:0]   diff;

  always_comb begin
    trial = {rem, quo[DVD_W-1]};
    fits  = trial >= {1'b0, dsr};
    diff  = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

  assign quotient = quo;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
`endif

endmodule

/* rtl/dwd_dp.sv */
// ----------------------------------------------------------------------------
// dwd_dp
// datapath: config, difference, weighted accumulation, divide, output register
// ----------------------------------------------------------------------------
module dwd_dp #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int MAX_BLOCK    = 32,
  parameter int MAX_SAMPLES  = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  dwd_pkg::cmd_t                    cmd,
  output dwd_pkg::stat_t                   stat,
  input  logic                             cfg_write_en,
  input  logic [dwd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dwd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample,
  input  logic                             last_sample,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic signed [SAMPLE_WIDTH-1:0]   block_average,
  output logic [dwd_pkg::IDX_W-1:0]        block_index
);

  localparam int PH_W  = $clog2(MAX_BLOCK);
  localparam int N_W   = $clog2(MAX_BLOCK + 1);
  localparam int WT_W  = $clog2(MAX_BLOCK / 2 + 1);
  localparam int VAL_W = SAMPLE_WIDTH + 1;
  localparam int PR_W  = WT_W + 1 + VAL_W;
  localparam int SUM_W = SAMPLE_WIDTH + 1 + 2 * PH_W;
  localparam int DIV_W = 2 * PH_W + 1;
  localparam int DVD_W = SUM_W + 1;
  localparam int POS_W = $clog2(MAX_SAMPLES);
  localparam int LIM   = 2 ** (SAMPLE_WIDTH - 1);

  // configuration
  logic                           collection_mode;
  logic [dwd_pkg::CFG_DATA_W-1:0] block_length;

  // waveform state
  logic signed [SAMPLE_WIDTH-1:0] previous_sample;
  logic signed [SAMPLE_WIDTH-1:0] held_sample;
  logic [POS_W-1:0]               sample_position;
  logic [PH_W-1:0]                block_phase;
  logic signed [SUM_W-1:0]        weighted_sum;
  logic [dwd_pkg::IDX_W-1:0]      output_count;

  // captured beat
  logic signed [SAMPLE_WIDTH-1:0] cap_x;
  logic                           cap_last;
  logic                           cap_feed;
  logic signed [VAL_W-1:0]        cap_val;

  // finished block waiting for the divider
  logic signed [SUM_W-1:0]        blk_sum;
  logic [dwd_pkg::IDX_W-1:0]      blk_index;
  logic [DIV_W-1:0]               half_div;

  // combinational
  logic                           pos_any;
  logic                           pos_one;
  logic signed [VAL_W-1:0]        diff;
  logic signed [VAL_W-1:0]        twice;
  logic [N_W-1:0]                 n_eff;
  logic [N_W-1:0]                 h_len;
  logic [N_W-1:0]                 h_inc;
  logic [N_W-1:0]                 k_ext;
  logic [N_W-1:0]                 wt_full;
  logic [WT_W-1:0]                weight;
  logic signed [PR_W-1:0]         product;
  logic signed [SUM_W-1:0]        sum1;
  logic signed [SUM_W-1:0]        sum_a;
  logic [N_W-1:0]                 ph_inc;
  logic                           comp1;
  logic [N_W-1:0]                 phase_a;
  logic                           comp2;
  logic                           block_done;
  logic [SUM_W-1:0]               blk_mag;
  logic [DVD_W-1:0]               dividend;
  logic [DIV_W-1:0]               divisor;
  logic [DVD_W-1:0]               quotient;
  logic                           div_done;
  logic [SAMPLE_WIDTH-1:0]        avg_sat;

  always_comb begin
    pos_any = sample_position != '0;
    pos_one = sample_position == POS_W'(1);
    diff    = VAL_W'(sample) - VAL_W'(previous_sample);
    twice   = $signed({sample, 1'b0});
  end

  // effective block length and triangular weight of the current phase
  always_comb begin
    if (32'(block_length) < 2) begin
      n_eff = N_W'(2);
    end else if (32'(block_length) > MAX_BLOCK) begin
      n_eff = N_W'(MAX_BLOCK);
    end else begin
      n_eff = N_W'(block_length);
    end
    h_len = n_eff >> 1;
    h_inc = h_len + 1'b1;
    k_ext = N_W'(block_phase);
    if (k_ext >= n_eff) begin
      wt_full = '0;
    end else if (k_ext < h_len) begin
      wt_full = k_ext + 1'b1;
    end else if (k_ext >= n_eff - h_len) begin
      wt_full = n_eff - k_ext;
    end else begin
      wt_full = '0;
    end
    weight = WT_W'(wt_full);
  end

  // accumulate; a last beat in collection mode feeds one more zero
  always_comb begin
    product    = $signed({1'b0, weight}) * cap_val;
    sum1       = weighted_sum + SUM_W'(product);
    ph_inc     = k_ext + 1'b1;
    comp1      = ph_inc >= n_eff;
    sum_a      = cap_feed ? sum1 : weighted_sum;
    phase_a    = cap_feed ? (comp1 ? '0 : ph_inc) : k_ext;
    comp2      = collection_mode && cap_last && !(cap_feed && comp1) &&
                 ((phase_a + 1'b1) >= n_eff);
    block_done = (cap_feed && comp1) || comp2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collection_mode <= dwd_pkg::RESET_COLLECTION_MODE;
      block_length    <= dwd_pkg::RESET_BLOCK_LENGTH;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        dwd_pkg::CFG_COLLECTION_MODE: collection_mode <= cfg_data[0];
        dwd_pkg::CFG_BLOCK_LENGTH:    block_length    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_x    <= sample;
      cap_last <= last_sample;
      cap_feed <= !collection_mode || pos_any;
      if (collection_mode) begin
        cap_val <= pos_one ? '0 : diff;
      end else begin
        cap_val <= twice;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      held_sample     <= '0;
      sample_position <= '0;
      block_phase     <= '0;
      weighted_sum    <= '0;
      output_count    <= '0;
    end else if (cmd.feed) begin
      if (cap_last) begin
        previous_sample <= '0;
        held_sample     <= '0;
        sample_position <= '0;
        block_phase     <= '0;
        weighted_sum    <= '0;
        output_count    <= '0;
      end else begin
        previous_sample <= held_sample;
        held_sample     <= cap_x;
        if (sample_position != POS_W'(MAX_SAMPLES - 1)) begin
          sample_position <= sample_position + 1'b1;
        end
        if (block_done) begin
          weighted_sum <= '0;
          block_phase  <= '0;
          output_count <= output_count + 1'b1;
        end else begin
          weighted_sum <= sum_a;
          block_phase  <= PH_W'(phase_a);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.feed && block_done) begin
      blk_sum   <= sum_a;
      blk_index <= output_count;
      half_div  <= DIV_W'(h_len * h_inc);
    end
  end

  // round to nearest, ties away from zero: (|sum| + d/2) / d
  always_comb begin
    blk_mag  = blk_sum[SUM_W-1] ? SUM_W'(-blk_sum) : SUM_W'(blk_sum);
    dividend = DVD_W'(blk_mag) + DVD_W'(half_div);
    divisor  = DIV_W'({half_div, 1'b0});
  end

  dwd_div #(
    .DVD_W (DVD_W),
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  always_comb begin
    if (blk_sum[SUM_W-1]) begin
      if (quotient > DVD_W'(LIM)) begin
        avg_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      end else begin
        avg_sat = SAMPLE_WIDTH'(~quotient + 1'b1);
      end
    end else begin
      if (quotient > DVD_W'(LIM - 1)) begin
        avg_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end else begin
        avg_sat = SAMPLE_WIDTH'(quotient);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      block_average <= $signed(avg_sat);
      block_index   <= blk_index;
    end
  end

  always_comb begin
    stat.block_done = block_done;
    stat.div_done   = div_done;
    stat.out_room   = !out_valid || out_ready;
  end

`ifndef ASSERT_OFF
  a_block_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.feed && block_done) |=> (weighted_sum == '0 && block_phase == '0))
    else $error("accumulator not cleared after block end");
`endif

endmodule

/* rtl/dwd_ctrl.sv */
// ----------------------------------------------------------------------------
// dwd_ctrl
// sequencer: accept, accumulate, divide, load output register
// ----------------------------------------------------------------------------
module dwd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dwd_pkg::stat_t stat,
  output dwd_pkg::cmd_t  cmd
);

  dwd_pkg::state_t state;
  dwd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dwd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      dwd_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = dwd_pkg::ST_FEED;
        end
      end
      dwd_pkg::ST_FEED: begin
        cmd.feed   = 1'b1;
        state_next = stat.block_done ? dwd_pkg::ST_DSTART : dwd_pkg::ST_IDLE;
      end
      dwd_pkg::ST_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = dwd_pkg::ST_DIV;
      end
      dwd_pkg::ST_DIV: begin
        if (stat.div_done) begin
          if (stat.out_room) begin
            cmd.load_out = 1'b1;
            state_next   = dwd_pkg::ST_IDLE;
          end else begin
            state_next = dwd_pkg::ST_LOAD;
          end
        end
      end
      dwd_pkg::ST_LOAD: begin
        if (stat.out_room) begin
          cmd.load_out = 1'b1;
          state_next   = dwd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dwd_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat taken while one is in work");
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> (state == dwd_pkg::ST_DIV))
    else $error("divider finished outside the divide state");
`endif

endmodule

/* rtl/derivative_weighted_decimator_core.sv */
// sequencing: each input beat is captured, then accumulated; a beat that
//   closes a block holds the input while the one-bit-per-cycle restoring
//   divider runs and until the average enters the output register
// reset: rst is synchronous, active high; clears the waveform state, output
//   register and sequencer, and loads collection_mode = 1, block_length = 10
// ----------------------------------------------------------------------------
// derivative_weighted_decimator_core
// streams samples, optionally takes the central difference, sums each block
// of N values with triangular weights and emits one rounded, saturated average
// ----------------------------------------------------------------------------
module derivative_weighted_decimator_core #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int MAX_BLOCK    = 32,
  parameter int MAX_SAMPLES  = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration writes: to be made only while idle; the block does not enforce it
  input  logic                           cfg_write_en,
  input  logic [dwd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dwd_pkg::CFG_DATA_W-1:0] cfg_data,
  // sample input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           last_sample,
  // block average output channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] block_average,
  output logic [dwd_pkg::IDX_W-1:0]      block_index
);

  // command and status between sequencer and datapath
  dwd_pkg::cmd_t  cmd;
  dwd_pkg::stat_t stat;

  // sequencer: one beat in work at a time; the divider runs only when a
  // block closes, and the output register lets the next beat in while a
  // finished average waits downstream
  dwd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: config registers, central difference against the sample two
  // beats back, weighted accumulate, rounding divide and saturation
  dwd_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .MAX_BLOCK    (MAX_BLOCK),
    .MAX_SAMPLES  (MAX_SAMPLES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample        (sample),
    .last_sample   (last_sample),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .block_average (block_average),
    .block_index   (block_index)
  );

endmodule

/* sim/dwd_block_checker.sv */
// ----------------------------------------------------------------------------
// dwd_block_checker
// watches the sample and average channels of the decimator, keeps its own
// model of the derivative and triangular block sum, and compares every
// average beat against the oldest predicted one
// ----------------------------------------------------------------------------
module dwd_block_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic [dwd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dwd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic signed [15:0]           sample,
  input  logic                         last_sample,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic signed [15:0]           block_average,
  input  logic [dwd_pkg::IDX_W-1:0]    block_index,
  output int                           pending_averages,
  output int                           mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN      = 32;
  localparam int POSITION_TOP = 4095;

  typedef struct packed {
    logic signed [15:0]        average;
    logic [dwd_pkg::IDX_W-1:0] index;
  } avg_beat_t;

  avg_beat_t expected_averages[$];

  // register copies
  logic                           diff_mode;
  logic [dwd_pkg::CFG_DATA_W-1:0] length_reg;

  // waveform state
  logic signed [15:0]        two_back;
  logic signed [15:0]        one_back;
  int                        position;
  int                        phase;
  longint                    block_sum;
  logic [dwd_pkg::IDX_W-1:0] avg_count;

  task automatic report_mismatch(input string what);
    $display("[%0t] average mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // adds one value in half-lsb units, closes the block when the phase is done
  task automatic accumulate_value(input longint value);
    int        n;
    int        h;
    longint    w;
    longint    div;
    longint    mag;
    longint    q;
    avg_beat_t beat;
    n = int'(length_reg);
    if (n < 2) n = 2;
    if (n > MAX_LEN) n = MAX_LEN;
    h = n / 2;
    if (phase >= n) w = 0;
    else if (phase < h) w = phase + 1;
    else if (phase >= n - h) w = n - phase;
    else w = 0;
    block_sum += w * value;
    if (phase + 1 < n) begin
      phase++;
    end else begin
      div = 2 * longint'(h) * longint'(h + 1);
      mag = (block_sum < 0) ? -block_sum : block_sum;
      q = (mag + div / 2) / div;
      if (block_sum < 0) q = -q;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      beat.average = q[15:0];
      beat.index   = avg_count;
      expected_averages.insert(expected_averages.size(), beat);
      avg_count++;
      block_sum = 0;
      phase     = 0;
    end
  endtask

  task automatic predict_block_averages(input logic signed [15:0] x, input logic is_last);
    if (diff_mode) begin
      if (position >= 1) begin
        // first sample of the waveform is forced to zero
        accumulate_value((position == 1) ? 64'sd0 : longint'(x) - longint'(two_back));
      end
      // last sample is forced to zero
      if (is_last) accumulate_value(0);
    end else begin
      accumulate_value(2 * longint'(x));
    end
    if (is_last) begin
      two_back  = '0;
      one_back  = '0;
      position  = 0;
      phase     = 0;
      block_sum = 0;
      avg_count = '0;
    end else begin
      two_back = one_back;
      one_back = x;
      if (position < POSITION_TOP) position++;
    end
  endtask

  always @(posedge clk) begin
    avg_beat_t want;
    if (rst) begin
      diff_mode  = dwd_pkg::RESET_COLLECTION_MODE;
      length_reg = dwd_pkg::RESET_BLOCK_LENGTH;
      two_back   = '0;
      one_back   = '0;
      position   = 0;
      phase      = 0;
      block_sum  = 0;
      avg_count  = '0;
      expected_averages.delete();
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          dwd_pkg::CFG_COLLECTION_MODE: diff_mode  = cfg_data[0];
          dwd_pkg::CFG_BLOCK_LENGTH:    length_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_block_averages(sample, last_sample);
      if (out_valid && out_ready) begin
        if (expected_averages.size() == 0) begin
          report_mismatch($sformatf("unexpected beat avg=%0d idx=%0d",
                                    block_average, block_index));
        end else begin
          want = expected_averages.pop_front();
          if (block_average !== want.average)
            report_mismatch($sformatf("block_average got %0d want %0d (idx %0d)",
                                      block_average, want.average, want.index));
          if (block_index !== want.index)
            report_mismatch($sformatf("block_index got %0d want %0d",
                                      block_index, want.index));
        end
      end
    end
    pending_averages = expected_averages.size();
  end

endmodule

/* sim/tb_derivative_weighted_decimator_core.sv */
// ----------------------------------------------------------------------------
// tb_derivative_weighted_decimator_core
// drives waveforms into the decimator with bursty input and a stalling
// output side, reconfigures mode and block length while idle, and lets the
// block checker judge every average beat
// ----------------------------------------------------------------------------
module tb_derivative_weighted_decimator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 1650;
  localparam int LONG_WAVE_LEN  = 280;   // shortest blocks back to back, output side backs up
  localparam int SETTLE_CYCLES  = 48;    // block latency plus margin
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int IDLE_LIMIT     = 2000;  // cycles without any beat before giving up

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE
  } rx_mode_t;

  logic                           clk;
  logic                           rst          = 1'b1;
  logic                           cfg_write_en = 1'b0;
  logic [dwd_pkg::CFG_IDX_W-1:0]  cfg_index    = dwd_pkg::CFG_COLLECTION_MODE;
  logic [dwd_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
  logic                           in_valid     = 1'b0;
  logic                           in_ready;
  logic signed [15:0]             sample       = '0;
  logic                           last_sample  = 1'b0;
  logic                           out_valid;
  logic                           out_ready    = 1'b0;
  logic signed [15:0]             block_average;
  logic [dwd_pkg::IDX_W-1:0]      block_index;

  int pending_averages;
  int mismatch_count;
  int items_sent = 0;
  int burst_left = 0;

  derivative_weighted_decimator_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample        (sample),
    .last_sample   (last_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .block_average (block_average),
    .block_index   (block_index)
  );

  dwd_block_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .sample           (sample),
    .last_sample      (last_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .block_average    (block_average),
    .block_index      (block_index),
    .pending_averages (pending_averages),
    .mismatch_count   (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one sample beat; a new burst starts with a random gap, sometimes none
  task automatic send_sample(input logic signed [15:0] value, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_valid    <= 1'b1;
    sample      <= value;
    last_sample <= is_last;
    // wait for the beat to be taken
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // stop offering, let every predicted average come out, then let a
  // block that produces nothing finish its work before touching registers
  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_averages != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [dwd_pkg::CFG_IDX_W-1:0] idx,
                                input logic [dwd_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(negedge clk) cfg_write_en <= 1'b0;
  endtask

  // block length: extremes, out-of-range values that clamp, else anything legal
  function automatic logic [dwd_pkg::CFG_DATA_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 6'd2;
    if (r == 1) return 6'd32;
    if (r == 2) return ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 1))
                                                   : 6'($urandom_range(33, 63));
    return 6'($urandom_range(2, 32));
  endfunction

  // sample content: extremes, a smooth walk from the last value, or noise
  function automatic logic signed [15:0] pick_sample(input logic signed [15:0] prev_x);
    int r;
    r = $urandom_range(0, 19);
    if (r < 3) begin
      case ($urandom_range(0, 4))
        0: return 16'sh7fff;
        1: return 16'sh8000;
        2: return 16'sh0000;
        3: return 16'shffff;
        default: return 16'sh0001;
      endcase
    end
    if (r < 8) return prev_x + 16'($urandom_range(0, 64)) - 16'sd32;
    return 16'($urandom);
  endfunction

  task automatic reconfigure();
    wait_idle();
    case ($urandom_range(0, 2))
      0: write_register(dwd_pkg::CFG_COLLECTION_MODE, 6'($urandom_range(0, 1)));
      1: write_register(dwd_pkg::CFG_BLOCK_LENGTH, pick_length());
      default: begin
        write_register(dwd_pkg::CFG_BLOCK_LENGTH, pick_length());
        write_register(dwd_pkg::CFG_COLLECTION_MODE, 6'($urandom_range(0, 1)));
      end
    endcase
  endtask

  // receiver: ready pattern is redrawn at random for random stretches, plus two long
  // hold-offs so the block backs up and stalls the sample side
  initial begin : receiver
    int       cyc;
    int       mode_left;
    rx_mode_t rx_mode;
    cyc       = 0;
    mode_left = 0;
    rx_mode   = RX_OPEN;
    forever begin
      @(negedge clk);
      cyc++;
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      if ((cyc >= 5000 && cyc < 5000 + HOLD_CYCLES) ||
          (cyc >= 40000 && cyc < 40000 + HOLD_CYCLES)) begin
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:  out_ready <= 1'b1;
          RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
          default:  out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // watchdog: too long without any beat on either channel means a hang
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int                 i;
    int                 wave_len;
    int                 split_at;
    int                 target;
    logic signed [15:0] x;
    x = '0;

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // ---- directed part ----
    // shortest blocks; second block of differences lands on the positive
    // rounding edge and saturates
    write_register(dwd_pkg::CFG_COLLECTION_MODE, 6'd1);
    write_register(dwd_pkg::CFG_BLOCK_LENGTH, 6'd2);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    // single-sample waveform, its one value is zero
    send_sample(16'sd12345, 1'b1);

    // pass-through, odd length so the middle weighs nothing; second block
    // is an exact half and rounds away from zero
    wait_idle();
    write_register(dwd_pkg::CFG_COLLECTION_MODE, 6'd0);
    write_register(dwd_pkg::CFG_BLOCK_LENGTH, 6'd3);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sh8000, 1'b1);

    // length shrunk below the current phase: next value closes the block
    wait_idle();
    write_register(dwd_pkg::CFG_BLOCK_LENGTH, 6'd32);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd200, 1'b0);
    send_sample(16'sd300, 1'b0);
    send_sample(-16'sd400, 1'b0);
    wait_idle();
    write_register(dwd_pkg::CFG_BLOCK_LENGTH, 6'd3);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd9, 1'b1);

    // mode flipped inside one waveform, both directions
    wait_idle();
    write_register(dwd_pkg::CFG_COLLECTION_MODE, 6'd1);
    write_register(dwd_pkg::CFG_BLOCK_LENGTH, 6'd2);
    send_sample(16'sd1000, 1'b0);
    send_sample(16'sd2000, 1'b0);
    wait_idle();
    write_register(dwd_pkg::CFG_COLLECTION_MODE, 6'd0);
    send_sample(16'sd3000, 1'b0);
    send_sample(16'sd4000, 1'b0);
    wait_idle();
    write_register(dwd_pkg::CFG_COLLECTION_MODE, 6'd1);
    send_sample(16'sd5000, 1'b0);
    send_sample(-16'sd6000, 1'b1);

    // ---- random waveforms ----
    // mostly short waveforms, a few long ones; some get a register change
    // partway through
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if ($urandom_range(0, 2) == 0) reconfigure();
      wave_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 60);
      split_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, wave_len) : -1;
      for (i = 0; i < wave_len; i++) begin
        if (i == split_at) reconfigure();
        x = pick_sample(x);
        send_sample(x, i == wave_len - 1);
      end
    end

    // ---- long waveform ----
    // shortest blocks so every other beat closes a block
    wait_idle();
    write_register(dwd_pkg::CFG_COLLECTION_MODE, 6'd1);
    write_register(dwd_pkg::CFG_BLOCK_LENGTH, 6'd2);
    for (i = 0; i < LONG_WAVE_LEN; i++) begin
      x = pick_sample(x);
      send_sample(x, i == LONG_WAVE_LEN - 1);
    end

    // drain, then leave room for any stray beat to show up
    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_averages == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* derivative_weighted_decimator_core.f */
rtl/dwd_pkg.sv
rtl/dwd_div.sv
rtl/dwd_dp.sv
rtl/dwd_ctrl.sv
rtl/derivative_weighted_decimator_core.sv
sim/dwd_block_checker.sv
sim/tb_derivative_weighted_decimator_core.sv
